// ===== rtl/core/stl_pkg.sv =====
// source token lexer package: lexer state, token types and the per-byte step function
// no dependencies; used by stl_lexer, stl_tok_queue, the top level and the testbench
`default_nettype none

package stl_pkg;

  // most token bytes one source byte can produce
  localparam int unsigned MaxTok     = 3;
  // default depth of the result queue, a power of two of at least four
  localparam int unsigned QueueDepth = 8;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChSlash = "/";
  localparam logic [7:0] ChStar  = "*";
  localparam logic [7:0] ChNl    = "\n";

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_STR,
    MODE_OP,
    MODE_LINE,
    MODE_BLOCK,
    MODE_BWORD,
    MODE_BSTR
  } mode_t;

  typedef enum logic [1:0] {
    KIND_WORD,
    KIND_STR,
    KIND_OP,
    KIND_SEP
  } kind_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] held_first;
    logic [7:0] held_second;
    logic [1:0] run_len;
  } lex_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      token_kind;
    logic       token_last;
  } tok_t;

  // up to three token bytes from one source byte, in order from tok[0]
  typedef struct packed {
    tok_t [2:0] tok;
    logic [1:0] cnt;
  } tok_batch_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || (c == "\t") || (c == "\n");
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == ",") || (c == ";") || (c == "{") || (c == "}") ||
           (c == "(") || (c == ")") || (c == ".");
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
           (c == "&") || (c == "|") || (c == "<") || (c == ">") ||
           (c == "^") || (c == "=") || (c == "!");
  endfunction

  function automatic logic ends_word(input logic [7:0] c);
    return is_space(c) || is_sep(c) || is_op(c);
  endfunction

  // append one token byte, dropping anything past the third
  function automatic void tok_push(inout tok_batch_t b, input logic [7:0] c,
                                   input kind_t k, input logic last);
    if (b.cnt != 2'd3) begin
      b.tok[b.cnt].out_byte   = c;
      b.tok[b.cnt].token_kind = k;
      b.tok[b.cnt].token_last = last;
      b.cnt                   = b.cnt + 2'd1;
    end
  endfunction

  // finish an operator run outside comments
  function automatic void close_op_run(inout lex_state_t s, inout tok_batch_t b);
    mode_t nxt;
    nxt = MODE_IDLE;
    unique case (s.run_len)
      2'd1: tok_push(b, s.held_first, KIND_OP, 1'b1);
      2'd2: begin
        if (s.held_first == ChSlash && s.held_second == ChSlash) begin
          nxt = MODE_LINE;
        end else if (s.held_first == ChSlash && s.held_second == ChStar) begin
          nxt = MODE_BLOCK;
        end else begin
          tok_push(b, s.held_first, KIND_OP, 1'b0);
          tok_push(b, s.held_second, KIND_OP, 1'b1);
        end
      end
      2'd3: tok_push(b, s.held_second, KIND_OP, 1'b1);
      default: ;
    endcase
    s.run_len = 2'd0;
    s.mode    = nxt;
  endfunction

  // add a byte to an operator run; when visible, earlier bytes go out once the run passes two
  function automatic void grow_run(inout lex_state_t s, inout tok_batch_t b,
                                   input logic [7:0] c, input logic visible);
    unique case (s.run_len)
      2'd1: begin
        s.held_second = c;
        s.run_len     = 2'd2;
      end
      2'd2: begin
        if (visible) begin
          tok_push(b, s.held_first, KIND_OP, 1'b0);
          tok_push(b, s.held_second, KIND_OP, 1'b0);
        end
        s.held_second = c;
        s.run_len     = 2'd3;
      end
      default: begin
        if (visible) begin
          tok_push(b, s.held_second, KIND_OP, 1'b0);
        end
        s.held_second = c;
        s.run_len     = 2'd3;
      end
    endcase
  endfunction

  function automatic void start_token(inout lex_state_t s, inout tok_batch_t b,
                                      input logic [7:0] c);
    if (is_space(c)) begin
      // skipped
    end else if (c == ChQuote) begin
      s.mode       = MODE_STR;
      s.held_first = c;
    end else if (is_op(c)) begin
      s.mode       = MODE_OP;
      s.held_first = c;
      s.run_len    = 2'd1;
    end else if (is_sep(c)) begin
      tok_push(b, c, KIND_SEP, 1'b1);
    end else begin
      s.mode       = MODE_WORD;
      s.held_first = c;
    end
  endfunction

  // one pass over the byte; again is set when the byte must be seen once more
  function automatic void lex_pass(inout lex_state_t s, inout tok_batch_t b,
                                   input logic [7:0] c, output logic again);
    logic closes;
    again  = 1'b0;
    closes = 1'b0;
    unique case (s.mode)
      MODE_IDLE: start_token(s, b, c);
      MODE_WORD: begin
        if (ends_word(c)) begin
          tok_push(b, s.held_first, KIND_WORD, 1'b1);
          s.mode = MODE_IDLE;
          again  = 1'b1;
        end else begin
          tok_push(b, s.held_first, KIND_WORD, 1'b0);
          s.held_first = c;
        end
      end
      MODE_STR: begin
        tok_push(b, s.held_first, KIND_STR, 1'b0);
        if (c == ChQuote) begin
          tok_push(b, c, KIND_STR, 1'b1);
          s.mode = MODE_IDLE;
        end else begin
          s.held_first = c;
        end
      end
      MODE_OP: begin
        if (is_op(c) && s.run_len != 2'd0) begin
          grow_run(s, b, c, 1'b1);
        end else begin
          close_op_run(s, b);
          again = 1'b1;
        end
      end
      MODE_LINE: begin
        if (c == ChNl) begin
          s.mode = MODE_IDLE;
        end
      end
      MODE_BLOCK: begin
        if (s.run_len == 2'd0) begin
          if (c == ChQuote) begin
            s.mode = MODE_BSTR;
          end else if (is_op(c)) begin
            s.held_first = c;
            s.run_len    = 2'd1;
          end else if (!is_space(c) && !is_sep(c)) begin
            s.mode = MODE_BWORD;
          end
        end else if (is_op(c)) begin
          grow_run(s, b, c, 1'b0);
        end else begin
          closes    = (s.run_len == 2'd2) && (s.held_first == ChStar) &&
                      (s.held_second == ChSlash);
          s.run_len = 2'd0;
          s.mode    = closes ? MODE_IDLE : MODE_BLOCK;
          again     = 1'b1;
        end
      end
      MODE_BWORD: begin
        if (ends_word(c)) begin
          s.mode = MODE_BLOCK;
          again  = 1'b1;
        end
      end
      MODE_BSTR: begin
        if (c == ChQuote) begin
          s.mode = MODE_BLOCK;
        end
      end
      default: ;
    endcase
  endfunction

  // full step for one transaction: next state and the token bytes it releases
  function automatic void lex_step(input lex_state_t s, input logic [7:0] c,
                                   input logic eoi, output lex_state_t ns,
                                   output tok_batch_t b);
    logic again;
    logic busy;
    ns    = s;
    b     = '0;
    again = 1'b0;
    busy  = 1'b1;
    if (eoi) begin
      // flush what is pending, then back to idle
      if (s.mode == MODE_WORD) begin
        tok_push(b, s.held_first, KIND_WORD, 1'b1);
      end else if (s.mode == MODE_STR) begin
        tok_push(b, s.held_first, KIND_STR, 1'b1);
      end else if (s.mode == MODE_OP) begin
        close_op_run(ns, b);
      end
      ns.mode    = MODE_IDLE;
      ns.run_len = 2'd0;
    end else begin
      for (int p = 0; p < 3; p++) begin
        if (busy) begin
          lex_pass(ns, b, c, again);
          busy = again;
        end
      end
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/stl_chan_if.sv =====
// channel interfaces of the source token lexer: source bytes in, token bytes out
// depends on nothing but the handshake convention valid/ready
`default_nettype none

interface stl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_input;

  modport source (output valid, output char_byte, output end_of_input, input ready);
  modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface stl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] token_kind;
  logic       token_last;

  modport source (output valid, output out_byte, output token_kind, output token_last,
                  input ready);
  modport sink   (input valid, input out_byte, input token_kind, input token_last,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/source_token_lexer_top.sv =====
// source token lexer top level: lexer step logic feeding a token byte result queue
// depends on stl_pkg, stl_in_if/stl_out_if, stl_lexer and stl_tok_queue
// release: a token byte is released by the transaction that brings it or by a later one, is
//   written to the queue when that transaction is accepted and shows on out_chan from the queue head
// throughput: one source byte per cycle while the queue holds room for three token bytes;
//   token bytes leave at one per cycle while out_chan is ready, set by the single queue read port
// reset: synchronous active low, returns the lexer to idle and empties the queue
`default_nettype none

module source_token_lexer_top
  import stl_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input logic      clk,
  input logic      rst_n,
  stl_in_if.sink   in_chan,
  stl_out_if.source out_chan
);

  logic       space_ok;
  logic       fire;
  tok_batch_t batch;
  tok_t       head;

  // a transaction is taken whenever the queue can absorb a full batch
  assign in_chan.ready = space_ok;
  assign fire          = in_chan.valid && space_ok;

  stl_lexer u_lexer (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .char_byte    (in_chan.char_byte),
    .end_of_input (in_chan.end_of_input),
    .batch        (batch)
  );

  stl_tok_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .batch     (batch),
    .space_ok  (space_ok),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .head      (head)
  );

  // result payload straight from the queue head
  assign out_chan.out_byte   = head.out_byte;
  assign out_chan.token_kind = head.token_kind;
  assign out_chan.token_last = head.token_last;

endmodule

`default_nettype wire

// ===== rtl/core/stl_lexer.sv =====
// lexer state register and the combinational step logic, with repeated passes, for one source byte
// depends on stl_pkg (state, token types, lex_step)
`default_nettype none

module stl_lexer
  import stl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] char_byte,
  input  logic       end_of_input,
  output tok_batch_t batch
);

  lex_state_t state_r;
  lex_state_t state_nxt;

  // next state and released token bytes for the byte on the input
  always_comb begin
    lex_step(state_r, char_byte, end_of_input, state_nxt, batch);
  end

  // state advances once per accepted transaction; held bytes need no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode    <= MODE_IDLE;
      state_r.run_len <= 2'd0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // end of input always leaves a clean idle state
  assert property (@(posedge clk) disable iff (!rst_n)
    fire && end_of_input |=> state_r.mode == MODE_IDLE && state_r.run_len == 2'd0)
    else $error("lexer not idle after end of input");

  // an operator run is never empty, and only runs and block comments keep a count
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.mode == MODE_OP) |-> state_r.run_len != 2'd0)
    else $error("operator mode with empty run");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.mode != MODE_OP && state_r.mode != MODE_BLOCK) |-> state_r.run_len == 2'd0)
    else $error("run count left over outside operator or block comment");

  // nothing inside a line comment, or a word or string in a block comment, is visible
  assert property (@(posedge clk) disable iff (!rst_n)
    fire && (state_r.mode == MODE_LINE || state_r.mode == MODE_BWORD ||
             state_r.mode == MODE_BSTR) |-> batch.cnt == 2'd0)
    else $error("token byte released inside a comment");

endmodule

`default_nettype wire

// ===== rtl/core/stl_tok_queue.sv =====
// result queue: takes up to three token bytes per cycle, hands out one per cycle when ready;
// depends on stl_pkg (tok_t, tok_batch_t, MaxTok); the user keeps Depth a power of two of at least four (not enforced)
`default_nettype none

module stl_tok_queue
  import stl_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tok_batch_t batch,
  output logic       space_ok,
  output logic       out_valid,
  input  logic       out_ready,
  output tok_t       head
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  tok_t            mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] cnt_r;
  logic [CntW-1:0] cnt_nxt;
  logic [CntW-1:0] push_cnt;
  logic            pop;

  // room for a full batch before a transaction is taken
  assign space_ok  = cnt_r <= CntW'(Depth - MaxTok);
  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && out_ready;
  assign head      = mem_r[rd_ptr_r];

  assign push_cnt   = push ? CntW'(batch.cnt) : '0;
  assign wr_ptr_nxt = wr_ptr_r + PtrW'(push_cnt);
  assign cnt_nxt    = cnt_r + push_cnt - CntW'(pop);

  // storage writes
  always_ff @(posedge clk) begin
    for (int k = 0; k < MaxTok; k++) begin
      if (push && (k < int'(batch.cnt))) begin
        mem_r[wr_ptr_r + PtrW'(k)] <= batch.tok[k];
      end
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // fill count never passes the depth
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CntW'(Depth))
    else $error("result queue overfilled");

  // count and pointers move together
  assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (cnt_r == CntW'(Depth) || cnt_r == '0) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== tb/source_token_lexer_top_tb.sv =====
// testbench for source_token_lexer_top: source bytes in, token bytes checked against a lexer predictor
// depends on stl_pkg, the stl_in_if/stl_out_if channel interfaces and the source_token_lexer_top rtl
// directed edge cases first, then random source text under several idle and stall mixes

module source_token_lexer_top_tb;
  import stl_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned MaxGap      = 12;
  localparam logic [7:0]  ChTab       = 8'h09;
  localparam logic [7:0]  ChSpace     = 8'h20;

  logic clk = 1'b0;
  logic rst_n;

  stl_in_if  in_chan ();
  stl_out_if out_chan ();

  source_token_lexer_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // lexer predictor state
  mode_t      lex_mode;
  logic [7:0] lex_pend;
  logic [7:0] lex_latest;
  logic [1:0] lex_run;

  tok_t       step_toks[$];
  tok_t       token_bytes_due[$];
  logic [8:0] src_text[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_requests = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;

  // character classes
  function automatic logic blank_ch(input logic [7:0] c);
    case (c)
      ChSpace, ChTab, ChNl: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic sep_ch(input logic [7:0] c);
    case (c)
      ",", ";", "{", "}", "(", ")", ".": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic op_ch(input logic [7:0] c);
    case (c)
      "+", "-", "*", "/", "&", "|", "<", ">", "^", "=", "!": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic word_break(input logic [7:0] c);
    return blank_ch(c) || sep_ch(c) || op_ch(c);
  endfunction

  // token byte for this step, at most three per source byte
  function automatic void put_tok(input logic [7:0] b, input kind_t k, input logic last);
    tok_t t;
    t.out_byte   = b;
    t.token_kind = k;
    t.token_last = last;
    if (step_toks.size() < MaxTok) begin
      step_toks.push_back(t);
    end
  endfunction

  // operator run finished outside a comment; "//" and "/*" open comments
  function automatic void end_op_run();
    mode_t nxt;
    nxt = MODE_IDLE;
    if (lex_run == 2'd1) begin
      put_tok(lex_pend, KIND_OP, 1'b1);
    end else if (lex_run == 2'd2) begin
      if (lex_pend == ChSlash && lex_latest == ChSlash) begin
        nxt = MODE_LINE;
      end else if (lex_pend == ChSlash && lex_latest == ChStar) begin
        nxt = MODE_BLOCK;
      end else begin
        put_tok(lex_pend, KIND_OP, 1'b0);
        put_tok(lex_latest, KIND_OP, 1'b1);
      end
    end else if (lex_run == 2'd3) begin
      put_tok(lex_latest, KIND_OP, 1'b1);
    end
    lex_run  = 2'd0;
    lex_mode = nxt;
  endfunction

  // one more operator byte; when shown, runs past two release their older bytes
  function automatic void extend_run(input logic [7:0] c, input logic shown);
    if (lex_run == 2'd1) begin
      lex_run = 2'd2;
    end else begin
      if (shown) begin
        if (lex_run == 2'd2) begin
          put_tok(lex_pend, KIND_OP, 1'b0);
        end
        put_tok(lex_latest, KIND_OP, 1'b0);
      end
      lex_run = 2'd3;
    end
    lex_latest = c;
  endfunction

  function automatic void lex_clear();
    lex_mode   = MODE_IDLE;
    lex_pend   = 8'h00;
    lex_latest = 8'h00;
    lex_run    = 2'd0;
  endfunction

  // expected token bytes for one accepted source transaction
  function automatic void lex_predict(input logic [7:0] c, input logic eoi);
    logic again;
    step_toks.delete();
    if (eoi) begin
      case (lex_mode)
        MODE_WORD: put_tok(lex_pend, KIND_WORD, 1'b1);
        MODE_STR:  put_tok(lex_pend, KIND_STR, 1'b1);
        MODE_OP:   end_op_run();
        default: ;
      endcase
      lex_clear();
    end else begin
      again = 1'b1;
      for (int n = 0; n < 3 && again; n++) begin
        again = 1'b0;
        case (lex_mode)
          MODE_IDLE: begin
            if (c == ChQuote) begin
              lex_mode = MODE_STR;
              lex_pend = c;
            end else if (op_ch(c)) begin
              lex_mode = MODE_OP;
              lex_pend = c;
              lex_run  = 2'd1;
            end else if (sep_ch(c)) begin
              put_tok(c, KIND_SEP, 1'b1);
            end else if (!blank_ch(c)) begin
              lex_mode = MODE_WORD;
              lex_pend = c;
            end
          end
          MODE_WORD: begin
            if (word_break(c)) begin
              put_tok(lex_pend, KIND_WORD, 1'b1);
              lex_mode = MODE_IDLE;
              again    = 1'b1;
            end else begin
              put_tok(lex_pend, KIND_WORD, 1'b0);
              lex_pend = c;
            end
          end
          MODE_STR: begin
            put_tok(lex_pend, KIND_STR, 1'b0);
            if (c == ChQuote) begin
              put_tok(c, KIND_STR, 1'b1);
              lex_mode = MODE_IDLE;
            end else begin
              lex_pend = c;
            end
          end
          MODE_OP: begin
            if (op_ch(c)) begin
              extend_run(c, 1'b1);
            end else begin
              end_op_run();
              again = 1'b1;
            end
          end
          MODE_LINE: begin
            if (c == ChNl) begin
              lex_mode = MODE_IDLE;
            end
          end
          MODE_BLOCK: begin
            // comment body is tokenized silently; only an exact "*/" run closes it
            if (lex_run == 2'd0) begin
              if (c == ChQuote) begin
                lex_mode = MODE_BSTR;
              end else if (op_ch(c)) begin
                lex_pend = c;
                lex_run  = 2'd1;
              end else if (!blank_ch(c) && !sep_ch(c)) begin
                lex_mode = MODE_BWORD;
              end
            end else if (op_ch(c)) begin
              extend_run(c, 1'b0);
            end else begin
              if (lex_run == 2'd2 && lex_pend == ChStar && lex_latest == ChSlash) begin
                lex_mode = MODE_IDLE;
              end
              lex_run = 2'd0;
              again   = 1'b1;
            end
          end
          MODE_BWORD: begin
            if (word_break(c)) begin
              lex_mode = MODE_BLOCK;
              again    = 1'b1;
            end
          end
          MODE_BSTR: begin
            if (c == ChQuote) begin
              lex_mode = MODE_BLOCK;
            end
          end
          default: ;
        endcase
      end
    end
    foreach (step_toks[i]) begin
      token_bytes_due.push_back(step_toks[i]);
    end
  endfunction

  // random character pickers
  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (word_break(b) || b == ChQuote);
    return b;
  endfunction

  function automatic logic [7:0] op_byte();
    case ($urandom_range(0, 10))
      0: return "+";
      1: return "-";
      2: return "*";
      3: return "/";
      4: return "&";
      5: return "|";
      6: return "<";
      7: return ">";
      8: return "^";
      9: return "=";
      default: return "!";
    endcase
  endfunction

  function automatic logic [7:0] sep_byte();
    case ($urandom_range(0, 6))
      0: return ",";
      1: return ";";
      2: return "{";
      3: return "}";
      4: return "(";
      5: return ")";
      default: return ".";
    endcase
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 2))
      0: return ChSpace;
      1: return ChTab;
      default: return ChNl;
    endcase
  endfunction

  function automatic void put_src(input logic [7:0] b);
    src_text.push_back({1'b0, b});
  endfunction

  // one piece of mostly well-formed source text, with some noise and early end of input
  function automatic void add_fragment();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      b = 8'($urandom_range(0, 255));
      src_text.push_back({1'b1, b});
    end else if (pick < 25) begin
      n = $urandom_range(1, 5);
      repeat (n) put_src(word_byte());
    end else if (pick < 37) begin
      put_src(ChQuote);
      n = $urandom_range(0, 4);
      repeat (n) begin
        do begin
          b = 8'($urandom_range(0, 255));
        end while (b == ChQuote);
        put_src(b);
      end
      put_src(ChQuote);
    end else if (pick < 52) begin
      n = $urandom_range(1, 4);
      repeat (n) put_src(op_byte());
    end else if (pick < 60) begin
      put_src(sep_byte());
    end else if (pick < 70) begin
      put_src(blank_byte());
    end else if (pick < 78) begin
      put_src(ChSlash);
      put_src(ChSlash);
      n = $urandom_range(0, 5);
      repeat (n) begin
        do begin
          b = 8'($urandom_range(0, 255));
        end while (b == ChNl);
        put_src(b);
      end
      put_src(ChNl);
    end else if (pick < 90) begin
      put_src(ChSlash);
      put_src(ChStar);
      put_src(ChSpace);
      n = $urandom_range(1, 4);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: begin
            repeat ($urandom_range(1, 3)) put_src(word_byte());
          end
          1: begin
            // a string, sometimes hiding a closing run, inside the comment
            put_src(ChQuote);
            if ($urandom_range(0, 1) == 1) begin
              put_src(ChStar);
              put_src(ChSlash);
            end
            repeat ($urandom_range(0, 2)) put_src(word_byte());
            put_src(ChQuote);
          end
          2: begin
            repeat ($urandom_range(1, 3)) put_src(op_byte());
          end
          default: put_src(sep_byte());
        endcase
        put_src(blank_byte());
      end
      put_src(ChStar);
      put_src(ChSlash);
      put_src(ChSpace);
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        b = 8'($urandom_range(0, 255));
        put_src(b);
      end
    end
  endfunction

  // send one source transaction, with random idle cycles ahead of it
  task automatic send_item(input logic [7:0] c, input logic eoi);
    int unsigned gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.char_byte    <= c;
    in_chan.end_of_input <= eoi;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    lex_predict(c, eoi);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], 1'b0);
    end
  endtask

  task automatic send_eoi();
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    send_item(junk, 1'b1);
  endtask

  // stop offering and wait for every expected token byte
  task automatic drain_phase();
    in_chan.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (token_bytes_due.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // zero and 0xff word bytes, quote inside a word, separator, unterminated string
  task automatic test_word_string_edges();
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b0);
    send_str("\",\"");
    send_eoi();
    drain_phase();
  endtask

  // long runs are plain operators, a pending "//" at end of input emits nothing
  task automatic test_operator_runs();
    send_str("+=<\t/**/ //");
    send_eoi();
    drain_phase();
  endtask

  // newline right after "//", block comment with a hidden close inside a string
  task automatic test_comment_forms();
    send_str("//\n/*\"*/\"*/.");
    send_eoi();
    drain_phase();
  endtask

  task automatic run_text(input int unsigned items);
    logic [8:0] s;
    for (int unsigned k = 0; k < items; k++) begin
      if (src_text.size() == 0) begin
        add_fragment();
      end
      s = src_text.pop_front();
      send_item(s[7:0], s[8]);
    end
    src_text.delete();
    send_eoi();
  endtask

  task automatic test_random_text(input int unsigned items, input int unsigned idle_pct,
                                  input int unsigned stall_in_pct);
    send_idle_pct = idle_pct;
    stall_pct     = stall_in_pct;
    run_text(items);
    drain_phase();
  endtask

  // receiver holds off while the sender keeps offering, so the block backs up
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_requests = hold_requests + 1;
    run_text(40);
    drain_phase();
  endtask

  // receiver ready, with random stalls and requested long hold-offs
  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = LongHold;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // check each token byte transaction against the oldest expectation
  always @(posedge clk) begin
    tok_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (token_bytes_due.size() == 0) begin
        $error("token byte %h arrived with no expectation waiting", out_chan.out_byte);
        mismatches++;
      end else begin
        want = token_bytes_due.pop_front();
        if (out_chan.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, actual %h", want.out_byte, out_chan.out_byte);
          mismatches++;
        end
        if (out_chan.token_kind !== want.token_kind) begin
          $error("token_kind: expected %0d, actual %0d", want.token_kind,
                 out_chan.token_kind);
          mismatches++;
        end
        if (out_chan.token_last !== want.token_last) begin
          $error("token_last: expected %0b, actual %0b", want.token_last,
                 out_chan.token_last);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.char_byte    <= 8'h00;
    in_chan.end_of_input <= 1'b0;
    lex_clear();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 17;
    stall_pct     = 17;
    test_word_string_edges();
    test_operator_runs();
    test_comment_forms();

    test_random_text(85, 0, 0);
    test_random_text(85, 51, 0);
    test_random_text(85, 0, 51);
    test_random_text(85, 17, 17);
    test_output_backpressure();

    if (mismatches == 0 && token_bytes_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (token_bytes_due.size() != 0) begin
        $error("%0d expected token bytes never arrived", token_bytes_due.size());
      end
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
